@@ design/tcrt_pkg.sv @@
// Shared types, constants and helper functions of the three-channel reload down timer.
package tcrt_pkg;

  localparam int MAX_CH      = 3;
  localparam int CH_W        = 2;
  localparam int DATA_W      = 32;
  localparam int IDX_W       = 4;
  localparam int CTRL_W      = 10;
  localparam int PRE_W       = 12;
  localparam int UNF_POS     = 8;
  localparam int UNIE_POS    = 5;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  localparam logic [IDX_W-1:0] IDX_START   = 4'd0;
  localparam logic [IDX_W-1:0] IDX_LAST    = 4'd9;
  localparam logic [IDX_W-1:0] REGS_PER_CH = 4'd3;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_WRITE = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    SUB_RELOAD = 2'd0,
    SUB_COUNT  = 2'd1,
    SUB_CTRL   = 2'd2
  } sub_t;

  typedef enum logic [2:0] {
    SEL_DIV4    = 3'd0,
    SEL_DIV16   = 3'd1,
    SEL_DIV64   = 3'd2,
    SEL_DIV256  = 3'd3,
    SEL_DIV1024 = 3'd4,
    SEL_DIV4096 = 3'd5,
    SEL_RTC     = 3'd6,
    SEL_EXT     = 3'd7
  } sel_t;

  // Per-channel command for one processed beat
  typedef struct packed {
    logic              tick;
    logic              rtc;
    logic              ext;
    logic              start_rise;
    logic              wr_reload;
    logic              wr_count;
    logic              wr_ctrl;
    logic [DATA_W-1:0] wdata;
  } chan_cmd_t;

  typedef struct packed {
    logic            hit;
    logic [CH_W-1:0] ch;
    sub_t            sub;
  } idx_dec_t;

  // Split a channel register index into channel and sub-register
  function automatic idx_dec_t decode_index(logic [IDX_W-1:0] idx);
    idx_dec_t         d;
    logic [IDX_W-1:0] off;
    off = idx - 4'd1;
    d.hit = (idx != IDX_START) && (idx <= IDX_LAST);
    if (off >= 2 * REGS_PER_CH) begin
      d.ch  = 2'd2;
      d.sub = sub_t'(2'(off - 2 * REGS_PER_CH));
    end else if (off >= REGS_PER_CH) begin
      d.ch  = 2'd1;
      d.sub = sub_t'(2'(off - REGS_PER_CH));
    end else begin
      d.ch  = 2'd0;
      d.sub = sub_t'(2'(off));
    end
    return d;
  endfunction

  // Prescaler pulse for the divided selects
  function automatic logic div_pulse(logic [PRE_W-1:0] p, sel_t sel);
    logic pulse;
    case (sel)
      SEL_DIV4:    pulse = (p[1:0] == '0);
      SEL_DIV16:   pulse = (p[3:0] == '0);
      SEL_DIV64:   pulse = (p[5:0] == '0);
      SEL_DIV256:  pulse = (p[7:0] == '0);
      SEL_DIV1024: pulse = (p[9:0] == '0);
      SEL_DIV4096: pulse = (p == '0);
      default:     pulse = 1'b0;
    endcase
    return pulse;
  endfunction

endpackage

@@ design/tcrt_channel.sv @@
// One timer channel: prescaler, down counter with reload, control word and flag.
module tcrt_channel import tcrt_pkg::*; #(
  parameter int COUNT_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  chan_cmd_t             cmd,
  output logic [COUNT_BITS-1:0] count,
  output logic [COUNT_BITS-1:0] reload,
  output logic [CTRL_W-1:0]     ctrl,
  output logic                  irq_nxt
);

  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [COUNT_BITS-1:0] reload_r, reload_nxt;
  logic [CTRL_W-1:0]     ctrl_r, ctrl_nxt;
  logic [PRE_W-1:0]      presc_r, presc_nxt, presc_inc;
  logic [CTRL_W-1:0]     wctrl;
  sel_t                  sel;
  logic                  pulse;

  assign sel       = sel_t'(ctrl_r[2:0]);
  assign presc_inc = presc_r + 12'd1;
  assign wctrl     = cmd.wdata[CTRL_W-1:0];

  always_comb begin
    unique case (sel)
      SEL_RTC: pulse = cmd.rtc;
      SEL_EXT: pulse = cmd.ext;
      default: pulse = div_pulse(presc_inc, sel);
    endcase
  end

  always_comb begin
    count_nxt  = count_r;
    reload_nxt = reload_r;
    ctrl_nxt   = ctrl_r;
    presc_nxt  = presc_r;
    if (cmd.tick) begin
      presc_nxt = presc_inc;
      if (pulse) begin
        if (count_r == '0) begin
          count_nxt         = reload_r;
          ctrl_nxt[UNF_POS] = 1'b1;
        end else begin
          count_nxt = count_r - 1'b1;
        end
      end
    end
    if (cmd.start_rise) presc_nxt = '0;
    if (cmd.wr_reload)  reload_nxt = cmd.wdata[COUNT_BITS-1:0];
    if (cmd.wr_count)   count_nxt  = cmd.wdata[COUNT_BITS-1:0];
    if (cmd.wr_ctrl) begin
      // flag can only be kept or cleared by software
      ctrl_nxt          = wctrl;
      ctrl_nxt[UNF_POS] = wctrl[UNF_POS] & ctrl_r[UNF_POS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      reload_r <= '0;
      ctrl_r   <= '0;
      presc_r  <= '0;
    end else begin
      count_r  <= count_nxt;
      reload_r <= reload_nxt;
      ctrl_r   <= ctrl_nxt;
      presc_r  <= presc_nxt;
    end
  end

  assign count   = count_r;
  assign reload  = reload_r;
  assign ctrl    = ctrl_r;
  assign irq_nxt = ctrl_nxt[UNF_POS] & ctrl_nxt[UNIE_POS];

  a_flag_not_set_by_write: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_ctrl && !ctrl_r[UNF_POS] |=> !ctrl_r[UNF_POS])
    else $error("underflow flag set by a control write");

  a_presc_clear_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start_rise |=> presc_r == '0)
    else $error("prescaler not cleared on start");

  a_count_idle_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.tick && !cmd.wr_count |=> $stable(count_r))
    else $error("count moved without a tick or write");

endmodule

@@ design/three_channel_reload_down_timer_unit.sv @@
// Top level of the three-channel reload down timer: input stage, decode, channels, result stage.
//
// Usage:
//   in_*  : one beat per request. tuser carries the request kind (tick, register
//           read, register write); tdata carries the register index, write data
//           and the RTC and external strobes that go with a tick.
//   out_* : exactly one result beat per request: read data (zero unless a read)
//           and the three interrupt lines as they stand after that request.
// Path: a beat accepted into the input register has its result placed in the
// result register, which drives out_* until the result is taken.
// Throughput: one beat per cycle while out_tready stays high; all per-request work is a single pass of
// increment, compare and select logic between the two registers.
// Reset: rst_n low clears start bits, counts, reloads, control words and
// prescalers, and empties both stages.
// Stall: when out_tready is low the result holds; the input stage still takes
// one more beat, then in_tready drops until the result is taken.
module three_channel_reload_down_timer_unit import tcrt_pkg::*; #(
  parameter int NUM_CHANNELS = 3,
  parameter int COUNT_BITS   = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [3:0] reg_index, [35:4] write_data, [36] rtc_tick, [37] ext_tick, [39:38] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [1:0] req_type
  input  logic [1:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [31:0] read_data, [34:32] irq_lines, [39:35] zero
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  // Input stage
  logic                   s1_valid_r, s1_valid_nxt;
  logic [1:0]             s1_req_r;
  logic [IDX_W-1:0]       s1_idx_r;
  logic [DATA_W-1:0]      s1_data_r;
  logic                   s1_rtc_r, s1_ext_r;
  logic                   in_fire, adv;

  // Result stage
  logic                   out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]      out_rd_r;
  logic [MAX_CH-1:0]      out_irq_r;

  logic [NUM_CHANNELS-1:0] run_r, run_nxt, run_wr;
  idx_dec_t                dec;
  logic                    is_tick, is_read, is_write;
  logic [DATA_W-1:0]       rd;
  logic [MAX_CH-1:0]       irq_all;

  chan_cmd_t               cmd   [NUM_CHANNELS];
  logic [COUNT_BITS-1:0]   cnt_w [NUM_CHANNELS];
  logic [COUNT_BITS-1:0]   rld_w [NUM_CHANNELS];
  logic [CTRL_W-1:0]       ctl_w [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] irq_w;

  // Advance the input stage whenever the result register is free or being drained
  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire)  s1_valid_nxt = 1'b1;
    else if (adv) s1_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Payload holds while the stage is full and not advancing
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r  <= in_tuser;
      s1_idx_r  <= in_tdata[3:0];
      s1_data_r <= in_tdata[35:4];
      s1_rtc_r  <= in_tdata[36];
      s1_ext_r  <= in_tdata[37];
    end
  end

  // Request decode, gated by the advance so state moves once per beat
  always_comb begin
    is_tick  = 1'b0;
    is_read  = 1'b0;
    is_write = 1'b0;
    unique case (s1_req_r)
      REQ_TICK:  is_tick  = adv;
      REQ_READ:  is_read  = adv;
      REQ_WRITE: is_write = adv;
      default: ;
    endcase
  end

  assign dec = decode_index(s1_idx_r);

  // Start bits: drop those beyond the channel count; note the rising edges
  always_comb begin
    run_nxt = run_r;
    run_wr  = s1_data_r[NUM_CHANNELS-1:0];
    if (is_write && s1_idx_r == IDX_START) run_nxt = run_wr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= '0;
    end else begin
      run_r <= run_nxt;
    end
  end

  for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_ch
    logic sel_hit;
    assign sel_hit = is_write && dec.hit && (dec.ch == CH_W'(c));

    always_comb begin
      cmd[c].tick       = is_tick && run_r[c];
      cmd[c].rtc        = s1_rtc_r;
      cmd[c].ext        = s1_ext_r;
      cmd[c].start_rise = is_write && (s1_idx_r == IDX_START) && run_wr[c] && !run_r[c];
      cmd[c].wr_reload  = sel_hit && (dec.sub == SUB_RELOAD);
      cmd[c].wr_count   = sel_hit && (dec.sub == SUB_COUNT);
      cmd[c].wr_ctrl    = sel_hit && (dec.sub == SUB_CTRL);
      cmd[c].wdata      = s1_data_r;
    end

    tcrt_channel #(
      .COUNT_BITS(COUNT_BITS)
    ) u_channel (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd[c]),
      .count   (cnt_w[c]),
      .reload  (rld_w[c]),
      .ctrl    (ctl_w[c]),
      .irq_nxt (irq_w[c])
    );
  end

  // Read mux: unused indexes and absent channels read as zero
  always_comb begin
    rd = '0;
    if (is_read) begin
      if (s1_idx_r == IDX_START) begin
        rd = DATA_W'(run_r);
      end else begin
        for (int c = 0; c < NUM_CHANNELS; c++) begin
          if (dec.hit && dec.ch == CH_W'(c)) begin
            case (dec.sub)
              SUB_RELOAD: rd = DATA_W'(rld_w[c]);
              SUB_COUNT:  rd = DATA_W'(cnt_w[c]);
              SUB_CTRL:   rd = DATA_W'(ctl_w[c]);
              default:    rd = '0;
            endcase
          end
        end
      end
    end
  end

  always_comb begin
    irq_all                 = '0;
    irq_all[NUM_CHANNELS-1:0] = irq_w;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv)             out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_rd_r  <= rd;
      out_irq_r <= irq_all;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_irq_r, out_rd_r};

  a_advance_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_tvalid)
    else $error("processed beat produced no result");

endmodule

@@ dv/timer_scoreboard_pkg.sv @@
// Scoreboard class for the three-channel reload down timer testbench.
`timescale 1ns / 1ps
package timer_scoreboard_pkg;
  import tcrt_pkg::*;

  localparam int N_CH = 3;

  typedef struct {
    logic [DATA_W-1:0] read_data;
    logic [N_CH-1:0]   irq;
  } timer_result_t;

  class timer_scoreboard;
    logic [N_CH-1:0]   start_bits;
    logic [DATA_W-1:0] counts[N_CH];
    logic [DATA_W-1:0] reloads[N_CH];
    logic [CTRL_W-1:0] ctrls[N_CH];
    logic [PRE_W-1:0]  prescalers[N_CH];
    timer_result_t     expected_results[$];
    int                errors;

    function new();
      start_bits = '0;
      errors     = 0;
      for (int c = 0; c < N_CH; c++) begin
        counts[c]     = '0;
        reloads[c]    = '0;
        ctrls[c]      = '0;
        prescalers[c] = '0;
      end
    endfunction

    // Advance the timer state by one accepted request and queue the result it gives
    function void note_request(logic [1:0] kind, logic [IDX_W-1:0] idx,
                               logic [DATA_W-1:0] wdata, logic rtc, logic ext);
      timer_result_t     res;
      logic [IDX_W-1:0]  off;
      int                ch;
      sub_t              sub;
      logic              pulse;
      int                div_mask;
      logic [CTRL_W-1:0] nv;
      res.read_data = '0;
      res.irq       = '0;
      off = idx - 4'd1;
      ch  = int'(off / REGS_PER_CH);
      sub = sub_t'(2'(off % REGS_PER_CH));
      if (kind == REQ_TICK) begin
        for (int c = 0; c < N_CH; c++) begin
          if (start_bits[c]) begin
            prescalers[c] = prescalers[c] + 1'b1;
            case (ctrls[c][2:0])
              SEL_RTC: pulse = rtc;
              SEL_EXT: pulse = ext;
              default: begin
                div_mask = (4 << (2 * ctrls[c][2:0])) - 1;
                pulse    = ((int'(prescalers[c]) & div_mask) == 0);
              end
            endcase
            if (pulse) begin
              // underflow: reload and raise the flag, otherwise count down
              if (counts[c] == '0) begin
                counts[c]         = reloads[c];
                ctrls[c][UNF_POS] = 1'b1;
              end else begin
                counts[c] = counts[c] - 1'b1;
              end
            end
          end
        end
      end else if (kind == REQ_READ) begin
        if (idx == IDX_START) begin
          res.read_data = DATA_W'(start_bits);
        end else if (idx <= IDX_LAST) begin
          case (sub)
            SUB_RELOAD: res.read_data = reloads[ch];
            SUB_COUNT:  res.read_data = counts[ch];
            default:    res.read_data = DATA_W'(ctrls[ch]);
          endcase
        end
      end else if (kind == REQ_WRITE) begin
        if (idx == IDX_START) begin
          // a channel that starts afresh restarts its prescaler
          for (int c = 0; c < N_CH; c++) begin
            if (wdata[c] && !start_bits[c]) prescalers[c] = '0;
          end
          start_bits = wdata[N_CH-1:0];
        end else if (idx <= IDX_LAST) begin
          case (sub)
            SUB_RELOAD: reloads[ch] = wdata;
            SUB_COUNT:  counts[ch]  = wdata;
            default: begin
              // the flag can only be kept or cleared, never set
              nv          = wdata[CTRL_W-1:0];
              nv[UNF_POS] = nv[UNF_POS] & ctrls[ch][UNF_POS];
              ctrls[ch]   = nv;
            end
          endcase
        end
      end
      for (int c = 0; c < N_CH; c++) begin
        res.irq[c] = ctrls[c][UNF_POS] & ctrls[c][UNIE_POS];
      end
      expected_results.push_back(res);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] beat);
      timer_result_t     want;
      logic [DATA_W-1:0] got_rd;
      logic [N_CH-1:0]   got_irq;
      got_rd  = beat[DATA_W-1:0];
      got_irq = beat[DATA_W +: N_CH];
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result beat with no request pending, actual %h", $time, beat);
        return;
      end
      want = expected_results.pop_front();
      if (got_rd !== want.read_data) begin
        errors++;
        $display("%0t: read_data mismatch, expected %h, actual %h",
                 $time, want.read_data, got_rd);
      end
      if (got_irq !== want.irq) begin
        errors++;
        $display("%0t: irq_lines mismatch, expected %b, actual %b",
                 $time, want.irq, got_irq);
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

endpackage

@@ dv/three_channel_reload_down_timer_unit_tb.sv @@
// Testbench top for the three-channel reload down timer: stimulus, back-pressure and checking.
`timescale 1ns / 1ps
module three_channel_reload_down_timer_unit_tb;
  import tcrt_pkg::*;
  import timer_scoreboard_pkg::*;

  localparam int N_RANDOM      = 450;
  localparam int IDLE_LIMIT    = 1000;
  localparam int HOLD_AFTER    = 150;
  localparam int HOLD_CYCLES   = 120;
  localparam int DRAIN_CYCLES  = 8;

  // request kind that the block must ignore
  localparam logic [1:0] REQ_SPARE = 2'd3;

  // register map
  localparam logic [IDX_W-1:0] IDX_RELOAD0 = 4'd1;
  localparam logic [IDX_W-1:0] IDX_COUNT0  = 4'd2;
  localparam logic [IDX_W-1:0] IDX_CTRL0   = 4'd3;
  localparam logic [IDX_W-1:0] IDX_CTRL1   = 4'd6;
  localparam logic [IDX_W-1:0] IDX_RELOAD2 = 4'd7;
  localparam logic [IDX_W-1:0] IDX_COUNT2  = 4'd8;
  localparam logic [IDX_W-1:0] IDX_CTRL2   = 4'd9;
  localparam logic [IDX_W-1:0] IDX_HOLE_LO = 4'd10;
  localparam logic [IDX_W-1:0] IDX_HOLE_MID = 4'd12;
  localparam logic [IDX_W-1:0] IDX_HOLE_HI = 4'd15;

  localparam logic [DATA_W-1:0] CTRL_UNIE = DATA_W'(1) << UNIE_POS;
  localparam logic [DATA_W-1:0] CTRL_UNF  = DATA_W'(1) << UNF_POS;
  localparam logic [DATA_W-1:0] ALL_ONES  = '1;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  // [3:0] reg_index, [35:4] write_data, [36] rtc_tick, [37] ext_tick, [39:38] zero
  logic [IN_TDATA_W-1:0]  in_tdata;
  // [1:0] req_type
  logic [1:0]             in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  // [31:0] read_data, [34:32] irq_lines, [39:35] zero
  logic [OUT_TDATA_W-1:0] out_tdata;

  timer_scoreboard sb = new();

  int n_in_beats  = 0;
  int idle_cycles = 0;
  int burst_left  = 0;

  three_channel_reload_down_timer_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  // Sample both channels at the edge: note accepted requests, check accepted
  // results, and end the run if the block stops moving beats altogether.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        sb.note_request(in_tuser, in_tdata[IDX_W-1:0], in_tdata[IDX_W +: DATA_W],
                        in_tdata[IDX_W+DATA_W], in_tdata[IDX_W+DATA_W+1]);
        n_in_beats++;
      end
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Offer one request and hold it until the block takes it. Between bursts,
  // drop tvalid for a random gap; long bursts give stretches with no gaps.
  task automatic send_request(input logic [1:0] kind, input logic [IDX_W-1:0] idx,
                              input logic [DATA_W-1:0] wdata, input logic rtc,
                              input logic ext);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {2'b00, ext, rtc, wdata, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Mostly ticks with small counts and fast selects so channels underflow
  // often; a sprinkle of wide values, hole indexes and the spare kind.
  task automatic random_request();
    int                pick;
    logic [1:0]        kind;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] wdata;
    logic [IDX_W-1:0]  off;
    wdata = $urandom;
    idx   = IDX_W'($urandom_range(0, 15));
    pick  = $urandom_range(0, 99);
    if (pick < 55) begin
      kind = REQ_TICK;
    end else if (pick < 75) begin
      kind = REQ_READ;
      if ($urandom_range(0, 4) != 0) idx = IDX_W'($urandom_range(0, 9));
    end else if (pick < 98) begin
      kind = REQ_WRITE;
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        // start bits: each channel mostly on
        idx = IDX_START;
        for (int c = 0; c < N_CH; c++) wdata[c] = ($urandom_range(0, 4) != 0);
      end else if (pick == 1) begin
        idx = IDX_W'($urandom_range(10, 15));
      end else begin
        idx = IDX_W'($urandom_range(1, 9));
        off = idx - 4'd1;
        if (sub_t'(2'(off % REGS_PER_CH)) == SUB_CTRL) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3: wdata[2:0] = SEL_DIV4;
            4, 5:       wdata[2:0] = SEL_DIV16;
            6:          wdata[2:0] = SEL_DIV64;
            7:          wdata[2:0] = SEL_RTC;
            8:          wdata[2:0] = SEL_EXT;
            default:    wdata[2:0] = 3'($urandom_range(0, 7));
          endcase
          wdata[UNIE_POS] = ($urandom_range(0, 3) != 0);
        end else if ($urandom_range(0, 4) != 0) begin
          wdata = DATA_W'($urandom_range(0, 5));
        end
      end
    end else begin
      kind = REQ_SPARE;
    end
    send_request(kind, idx, wdata, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // Result side: rotate through always-ready, light, periodic and heavy stall
  // patterns; once, well into the run, hold off long enough to fill the block.
  initial begin : result_side
    int cyc;
    bit held;
    cyc  = 0;
    held = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (!held && n_in_beats >= HOLD_AFTER) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        case ((cyc / 80) % 4)
          0:       out_tready <= 1'b1;
          1:       out_tready <= ($urandom_range(0, 3) != 0);
          2:       out_tready <= ((cyc % 5) != 0);
          default: out_tready <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  initial begin : request_side
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= REQ_TICK;
    in_tdata  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: state after reset, wide writes, both strobes, flag
    // keep and clear, zero reload, hole indexes, spare kind, start and stop.
    send_request(REQ_READ,  IDX_START,    '0,        1'b0, 1'b0);
    // all ones: flag must not set, select external, enable on
    send_request(REQ_WRITE, IDX_CTRL0,    ALL_ONES,  1'b0, 1'b0);
    send_request(REQ_READ,  IDX_CTRL0,    '0,        1'b0, 1'b0);
    send_request(REQ_WRITE, IDX_RELOAD0,  ALL_ONES,  1'b0, 1'b0);
    // start bits beyond the channel count are dropped
    send_request(REQ_WRITE, IDX_START,    ALL_ONES,  1'b0, 1'b0);
    // count is zero: the external strobe underflows channel 0 to the top value
    send_request(REQ_TICK,  IDX_START,    '0,        1'b0, 1'b1);
    send_request(REQ_READ,  IDX_COUNT0,   '0,        1'b0, 1'b0);
    // written flag of one keeps the flag
    send_request(REQ_WRITE, IDX_CTRL0,    CTRL_UNF | CTRL_UNIE | SEL_EXT, 1'b0, 1'b0);
    send_request(REQ_READ,  IDX_CTRL0,    '0,        1'b0, 1'b0);
    send_request(REQ_WRITE, IDX_CTRL1,    CTRL_UNIE | SEL_RTC, 1'b0, 1'b0);
    send_request(REQ_TICK,  IDX_START,    '0,        1'b1, 1'b1);
    // strobes on register accesses are ignored
    send_request(REQ_READ,  IDX_CTRL0,    '0,        1'b1, 1'b1);
    send_request(REQ_WRITE, IDX_CTRL0,    '0,        1'b1, 1'b1);
    // channel 2 at divide by four with zero reload underflows every pulse
    send_request(REQ_WRITE, IDX_CTRL2,    CTRL_UNIE | SEL_DIV4, 1'b0, 1'b0);
    send_request(REQ_TICK,  IDX_START,    '0,        1'b0, 1'b0);
    send_request(REQ_TICK,  IDX_START,    '0,        1'b0, 1'b0);
    send_request(REQ_WRITE, IDX_HOLE_MID, ALL_ONES,  1'b0, 1'b0);
    send_request(REQ_READ,  IDX_HOLE_HI,  '0,        1'b0, 1'b0);
    send_request(REQ_READ,  IDX_HOLE_LO,  '0,        1'b0, 1'b0);
    send_request(REQ_SPARE, IDX_START,    ALL_ONES,  1'b1, 1'b1);
    send_request(REQ_WRITE, IDX_COUNT0,   '0,        1'b0, 1'b0);
    send_request(REQ_WRITE, IDX_RELOAD2,  32'd3,     1'b0, 1'b0);
    // stop everything, tick, then restart channels 0 and 2
    send_request(REQ_WRITE, IDX_START,    '0,        1'b0, 1'b0);
    send_request(REQ_TICK,  IDX_START,    '0,        1'b1, 1'b1);
    send_request(REQ_WRITE, IDX_START,    32'd5,     1'b0, 1'b0);
    send_request(REQ_READ,  IDX_COUNT2,   '0,        1'b0, 1'b0);

    repeat (N_RANDOM) random_request();
    in_tvalid <= 1'b0;
    // let the monitor note the last accepted request first
    @(posedge clk);

    // Drain: wait for every outstanding result, then keep watching the result side to
    // catch any stray beat.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
